// ===== hdl/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared widths, constants, codes and payload types of the scan-out scaler.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int unsigned ADDR_BITS = 23;
  localparam int unsigned DIM_BITS  = 12;
  localparam int unsigned PROD_BITS = 2 * DIM_BITS;
  localparam int unsigned CFG_BITS  = (ADDR_BITS > DIM_BITS) ? ADDR_BITS : DIM_BITS;
  localparam int unsigned IDX_BITS  = 3;

  localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;

  // pixel size code that selects four-byte pixels
  localparam logic [1:0] PSC_RGBA8888 = 2'd3;

  // register reset values
  localparam logic [DIM_BITS-1:0] RST_SRC_W = DIM_BITS'(320);
  localparam logic [DIM_BITS-1:0] RST_SRC_H = DIM_BITS'(240);
  localparam logic [DIM_BITS-1:0] RST_OUT_W = DIM_BITS'(320);
  localparam logic [DIM_BITS-1:0] RST_OUT_H = DIM_BITS'(240);
  localparam logic [1:0]          RST_PSC   = 2'd2;

  typedef enum logic [IDX_BITS-1:0] {
    CFG_FRAME_ORIGIN    = 3'd0,
    CFG_SOURCE_WIDTH    = 3'd1,
    CFG_SOURCE_HEIGHT   = 3'd2,
    CFG_PIXEL_SIZE_CODE = 3'd3,
    CFG_BLANK_ENABLE    = 3'd4,
    CFG_OUTPUT_WIDTH    = 3'd5,
    CFG_OUTPUT_HEIGHT   = 3'd6
  } sfs_cfg_idx_e;

  typedef struct packed {
    logic                req_type;
    logic [DIM_BITS-1:0] out_x;
    logic [DIM_BITS-1:0] out_y;
    logic [31:0]         pixel_bits;
  } sfs_in_t;

  typedef struct packed {
    logic                 fetch_valid;
    logic [ADDR_BITS-1:0] first_addr;
    logic [ADDR_BITS-1:0] second_addr;
    logic                 needs_second;
    logic [31:0]          argb_pixel;
    logic                 coord_error;
  } sfs_out_t;

  // divider pipeline stage: partial quotients and running remainders
  typedef struct packed {
    logic                 req;
    logic                 cerr;
    logic                 blank;
    logic [31:0]          argb;
    logic [DIM_BITS-1:0]  qx;
    logic [DIM_BITS-1:0]  qy;
    logic [PROD_BITS-1:0] rx;
    logic [PROD_BITS-1:0] ry;
  } sfs_div_t;

  // address pipeline stage: line offset product and column
  typedef struct packed {
    logic                 req;
    logic                 cerr;
    logic                 blank;
    logic [31:0]          argb;
    logic [DIM_BITS-1:0]  qx;
    logic [PROD_BITS-1:0] prod;
  } sfs_adr_t;

endpackage

// ===== hdl/scaled_framebuffer_scanout.sv =====
// ----------------------------------------------------------------------------
// scaled_framebuffer_scanout
// Pipeline: 15 register stages (entry stage, one stage per quotient bit of the
// 12-bit dividers, multiply and address sum).
// Throughput: one item per cycle while the output is taken or a stage is empty;
// each stage advances when it or any later stage holds a bubble, so a stalled
// output still lets the pipe fill up.
// Reset: all valid bits clear, registers take their documented defaults.
// ----------------------------------------------------------------------------
module scaled_framebuffer_scanout (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // item input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sfs_pkg::sfs_in_t                in_data_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sfs_pkg::sfs_out_t               out_data_o,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [sfs_pkg::IDX_BITS-1:0]    cfg_idx_i,
  input  logic [sfs_pkg::CFG_BITS-1:0]    cfg_wdata_i
);

  localparam int unsigned DW  = sfs_pkg::DIM_BITS;
  // entry stage + one per quotient bit + multiply + sum
  localparam int unsigned NST = DW + 3;

  // --------------------------------------------------------------------------
  // Configuration registers. Every stage reads them live, so the user must write
  // them only while the pipe is empty; the block does not enforce this.
  // --------------------------------------------------------------------------
  logic [sfs_pkg::ADDR_BITS-1:0] origin_q;
  logic [DW-1:0]                 src_w_q, src_h_q, out_w_q, out_h_q;
  logic [1:0]                    psc_q;
  logic                          blank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      src_w_q  <= sfs_pkg::RST_SRC_W;
      src_h_q  <= sfs_pkg::RST_SRC_H;
      psc_q    <= sfs_pkg::RST_PSC;
      blank_q  <= 1'b1;
      out_w_q  <= sfs_pkg::RST_OUT_W;
      out_h_q  <= sfs_pkg::RST_OUT_H;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfs_pkg::CFG_FRAME_ORIGIN:    origin_q <= cfg_wdata_i[sfs_pkg::ADDR_BITS-1:0];
        sfs_pkg::CFG_SOURCE_WIDTH:    src_w_q  <= cfg_wdata_i[DW-1:0];
        sfs_pkg::CFG_SOURCE_HEIGHT:   src_h_q  <= cfg_wdata_i[DW-1:0];
        sfs_pkg::CFG_PIXEL_SIZE_CODE: psc_q    <= cfg_wdata_i[1:0];
        sfs_pkg::CFG_BLANK_ENABLE:    blank_q  <= cfg_wdata_i[0];
        sfs_pkg::CFG_OUTPUT_WIDTH:    out_w_q  <= cfg_wdata_i[DW-1:0];
        sfs_pkg::CFG_OUTPUT_HEIGHT:   out_h_q  <= cfg_wdata_i[DW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. Stage k may load when the output is taken or some
  // stage from k onward is empty; bubbles collapse, nothing is overwritten.
  // --------------------------------------------------------------------------
  logic [NST-1:0] v_d, v_q;
  logic [NST-1:0] en;

  always_comb begin
    for (int unsigned k = 0; k < NST; k++) begin
      en[k] = out_ready_i || ((v_q | ((NST'(1) << k) - NST'(1))) != '1);
    end
  end

  always_comb begin
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int unsigned k = 1; k < NST; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NST-1];

  // --------------------------------------------------------------------------
  // Datapath: entry stage, restoring divider (MSB first), address stages.
  // --------------------------------------------------------------------------
  sfs_pkg::sfs_div_t stg [DW+1];

  sfs_front u_front (
    .clk_i      (clk_i),
    .en_i       (en[0]),
    .in_i       (in_data_i),
    .src_w_i    (src_w_q),
    .src_h_i    (src_h_q),
    .out_w_i    (out_w_q),
    .out_h_i    (out_h_q),
    .psc_i      (psc_q),
    .blank_en_i (blank_q),
    .stg_o      (stg[0])
  );

  for (genvar k = 0; k < DW; k++) begin : g_div
    sfs_div_step #(
      .STEP (DW - 1 - k)
    ) u_step (
      .clk_i   (clk_i),
      .en_i    (en[k+1]),
      .stg_i   (stg[k]),
      .out_w_i (out_w_q),
      .out_h_i (out_h_q),
      .stg_o   (stg[k+1])
    );
  end

  sfs_addr u_addr (
    .clk_i    (clk_i),
    .en_mul_i (en[DW+1]),
    .en_sum_i (en[DW+2]),
    .stg_i    (stg[DW]),
    .src_w_i  (src_w_q),
    .origin_i (origin_q),
    .psc_i    (psc_q),
    .out_o    (out_data_o)
  );

endmodule

// ===== hdl/sfs_front.sv =====
// ----------------------------------------------------------------------------
// sfs_front
// Entry stage: coordinate products, range check, blanking and pixel decode.
// ----------------------------------------------------------------------------
module sfs_front (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  sfs_pkg::sfs_in_t             in_i,
  input  logic [sfs_pkg::DIM_BITS-1:0] src_w_i,
  input  logic [sfs_pkg::DIM_BITS-1:0] src_h_i,
  input  logic [sfs_pkg::DIM_BITS-1:0] out_w_i,
  input  logic [sfs_pkg::DIM_BITS-1:0] out_h_i,
  input  logic [1:0]                   psc_i,
  input  logic                         blank_en_i,
  output sfs_pkg::sfs_div_t            stg_o
);

  sfs_pkg::sfs_div_t stg_d, stg_q;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [31:0] decode(input logic [31:0] bits, input logic wide);
    logic [31:0] res;
    if (wide) begin
      res = sfs_pkg::OPAQUE_BLACK | {8'h00, bits[31:24], bits[23:16], bits[15:8]};
    end else begin
      res = sfs_pkg::OPAQUE_BLACK |
            {8'h00, widen5(bits[15:11]), widen5(bits[10:6]), widen5(bits[5:1])};
    end
    return res;
  endfunction

  always_comb begin
    stg_d       = '0;
    stg_d.req   = in_i.req_type;
    stg_d.blank = blank_en_i || (src_w_i == '0) || (src_h_i == '0);
    stg_d.cerr  = !in_i.req_type && ((in_i.out_x >= out_w_i) || (in_i.out_y >= out_h_i));
    stg_d.argb  = decode(in_i.pixel_bits, psc_i == sfs_pkg::PSC_RGBA8888);
    stg_d.rx    = sfs_pkg::PROD_BITS'(in_i.out_x) * sfs_pkg::PROD_BITS'(src_w_i);
    stg_d.ry    = sfs_pkg::PROD_BITS'(in_i.out_y) * sfs_pkg::PROD_BITS'(src_h_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q <= stg_d;
    end
  end

  assign stg_o = stg_q;

endmodule

// ===== hdl/sfs_div_step.sv =====
// ----------------------------------------------------------------------------
// sfs_div_step
// One restoring-division step for both coordinates, one quotient bit each.
// ----------------------------------------------------------------------------
module sfs_div_step #(
  parameter int unsigned STEP = 0
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  sfs_pkg::sfs_div_t            stg_i,
  input  logic [sfs_pkg::DIM_BITS-1:0] out_w_i,
  input  logic [sfs_pkg::DIM_BITS-1:0] out_h_i,
  output sfs_pkg::sfs_div_t            stg_o
);

  logic [sfs_pkg::PROD_BITS-1:0] dx, dy;
  sfs_pkg::sfs_div_t             stg_d, stg_q;

  assign dx = sfs_pkg::PROD_BITS'(out_w_i) << STEP;
  assign dy = sfs_pkg::PROD_BITS'(out_h_i) << STEP;

  always_comb begin
    stg_d = stg_i;
    if (stg_i.rx >= dx) begin
      stg_d.rx       = stg_i.rx - dx;
      stg_d.qx[STEP] = 1'b1;
    end
    if (stg_i.ry >= dy) begin
      stg_d.ry       = stg_i.ry - dy;
      stg_d.qy[STEP] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q <= stg_d;
    end
  end

  assign stg_o = stg_q;

endmodule

// ===== hdl/sfs_addr.sv =====
// ----------------------------------------------------------------------------
// sfs_addr
// Two stages: line offset multiply, then byte address sum and result build.
// ----------------------------------------------------------------------------
module sfs_addr (
  input  logic                          clk_i,
  input  logic                          en_mul_i,
  input  logic                          en_sum_i,
  input  sfs_pkg::sfs_div_t             stg_i,
  input  logic [sfs_pkg::DIM_BITS-1:0]  src_w_i,
  input  logic [sfs_pkg::ADDR_BITS-1:0] origin_i,
  input  logic [1:0]                    psc_i,
  output sfs_pkg::sfs_out_t             out_o
);

  localparam int unsigned AW = sfs_pkg::ADDR_BITS;

  sfs_pkg::sfs_adr_t adr_d, adr_q;
  sfs_pkg::sfs_out_t out_d, out_q;
  logic              wide;
  logic [AW-1:0]     pix_idx, byte_off, a1;

  always_comb begin
    adr_d.req   = stg_i.req;
    adr_d.cerr  = stg_i.cerr;
    adr_d.blank = stg_i.blank;
    adr_d.argb  = stg_i.argb;
    adr_d.qx    = stg_i.qx;
    adr_d.prod  = sfs_pkg::PROD_BITS'(stg_i.qy) * sfs_pkg::PROD_BITS'(src_w_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_mul_i) begin
      adr_q <= adr_d;
    end
  end

  assign wide     = (psc_i == sfs_pkg::PSC_RGBA8888);
  assign pix_idx  = AW'(adr_q.prod) + AW'(adr_q.qx);
  assign byte_off = wide ? (pix_idx << 2) : (pix_idx << 1);
  assign a1       = origin_i + byte_off;

  always_comb begin
    out_d = '0;
    if (adr_q.blank) begin
      out_d.argb_pixel  = sfs_pkg::OPAQUE_BLACK;
      out_d.coord_error = adr_q.cerr;
    end else if (adr_q.req) begin
      out_d.fetch_valid = 1'b1;
      out_d.argb_pixel  = adr_q.argb;
    end else if (adr_q.cerr) begin
      out_d.coord_error = 1'b1;
    end else begin
      out_d.fetch_valid  = 1'b1;
      out_d.first_addr   = a1;
      out_d.needs_second = wide;
      out_d.second_addr  = wide ? (a1 + AW'(2)) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_sum_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// ===== bench/scaled_framebuffer_scanout_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_framebuffer_scanout_tb
// Self-checking bench for the scan-out scaler. Drives locate and decode
// transfers under a series of register settings, predicts every result
// in a scoreboard and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module scaled_framebuffer_scanout_tb;

  // item kinds
  localparam logic REQ_LOCATE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // register index with no register behind it; writes must be dropped
  localparam logic [sfs_pkg::IDX_BITS-1:0] CFG_NO_REG = 3'd7;

  // a two-byte pixel code other than the reset one
  localparam logic [1:0] PSC_RGBA5551 = 2'd0;

  localparam int unsigned RAND_PHASES     = 15;
  localparam int unsigned ITEMS_PER_PHASE = 70;

  // ---------------------------------------------------------------------------
  // Scoreboard: shadow registers, predictor and queue of awaited results.
  // ---------------------------------------------------------------------------
  class scanout_scoreboard;
    logic [sfs_pkg::ADDR_BITS-1:0] origin   = '0;
    logic [sfs_pkg::DIM_BITS-1:0]  src_w    = sfs_pkg::RST_SRC_W;
    logic [sfs_pkg::DIM_BITS-1:0]  src_h    = sfs_pkg::RST_SRC_H;
    logic [1:0]                    psc      = sfs_pkg::RST_PSC;
    logic                          blank_en = 1'b1;
    logic [sfs_pkg::DIM_BITS-1:0]  out_w    = sfs_pkg::RST_OUT_W;
    logic [sfs_pkg::DIM_BITS-1:0]  out_h    = sfs_pkg::RST_OUT_H;

    sfs_pkg::sfs_out_t predicted_results[$];
    int unsigned errors = 0;

    function void write_reg(logic [sfs_pkg::IDX_BITS-1:0] idx,
                            logic [sfs_pkg::CFG_BITS-1:0] data);
      unique case (idx)
        sfs_pkg::CFG_FRAME_ORIGIN:    origin   = data[sfs_pkg::ADDR_BITS-1:0];
        sfs_pkg::CFG_SOURCE_WIDTH:    src_w    = data[sfs_pkg::DIM_BITS-1:0];
        sfs_pkg::CFG_SOURCE_HEIGHT:   src_h    = data[sfs_pkg::DIM_BITS-1:0];
        sfs_pkg::CFG_PIXEL_SIZE_CODE: psc      = data[1:0];
        sfs_pkg::CFG_BLANK_ENABLE:    blank_en = data[0];
        sfs_pkg::CFG_OUTPUT_WIDTH:    out_w    = data[sfs_pkg::DIM_BITS-1:0];
        sfs_pkg::CFG_OUTPUT_HEIGHT:   out_h    = data[sfs_pkg::DIM_BITS-1:0];
        default: ;
      endcase
    endfunction

    // nearest-neighbor source lookup, or pixel expansion to opaque ARGB
    function sfs_pkg::sfs_out_t scale_and_decode(sfs_pkg::sfs_in_t item);
      sfs_pkg::sfs_out_t res;
      logic              blanking;
      logic [63:0]       sx, sy, bpp, addr;
      logic [7:0]        rr, gg, bb;
      res = '0;
      blanking = blank_en || (src_w == '0) || (src_h == '0);
      if (item.req_type == REQ_LOCATE) begin
        res.coord_error = (item.out_x >= out_w) || (item.out_y >= out_h);
        if (blanking) begin
          res.argb_pixel = sfs_pkg::OPAQUE_BLACK;
        end else if (!res.coord_error) begin
          bpp  = (psc == sfs_pkg::PSC_RGBA8888) ? 64'd4 : 64'd2;
          sy   = (64'(item.out_y) * 64'(src_h)) / 64'(out_h);
          sx   = (64'(item.out_x) * 64'(src_w)) / 64'(out_w);
          addr = 64'(origin) + sy * 64'(src_w) * bpp + sx * bpp;
          res.first_addr  = addr[sfs_pkg::ADDR_BITS-1:0];
          res.fetch_valid = 1'b1;
          if (psc == sfs_pkg::PSC_RGBA8888) begin
            res.needs_second = 1'b1;
            res.second_addr  = res.first_addr + sfs_pkg::ADDR_BITS'(2);
          end
        end
      end else if (blanking) begin
        res.argb_pixel = sfs_pkg::OPAQUE_BLACK;
      end else begin
        res.fetch_valid = 1'b1;
        if (psc == sfs_pkg::PSC_RGBA8888) begin
          rr = item.pixel_bits[31:24];
          gg = item.pixel_bits[23:16];
          bb = item.pixel_bits[15:8];
        end else begin
          // 5-bit channels widened by replicating their top bits
          rr = {item.pixel_bits[15:11], item.pixel_bits[15:13]};
          gg = {item.pixel_bits[10:6],  item.pixel_bits[10:8]};
          bb = {item.pixel_bits[5:1],   item.pixel_bits[5:3]};
        end
        res.argb_pixel = sfs_pkg::OPAQUE_BLACK | {8'h00, rr, gg, bb};
      end
      return res;
    endfunction

    function void note_input(sfs_pkg::sfs_in_t item);
      predicted_results.push_back(scale_and_decode(item));
    endfunction

    function void check_result(sfs_pkg::sfs_out_t got);
      sfs_pkg::sfs_out_t exp;
      if (predicted_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing awaited: %h", $realtime, got);
        return;
      end
      exp = predicted_results.pop_front();
      if (got.fetch_valid  !== exp.fetch_valid  ||
          got.first_addr   !== exp.first_addr   ||
          got.second_addr  !== exp.second_addr  ||
          got.needs_second !== exp.needs_second ||
          got.argb_pixel   !== exp.argb_pixel   ||
          got.coord_error  !== exp.coord_error) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp fv=%b a1=%h a2=%h ns=%b argb=%h ce=%b",
                   $realtime, exp.fetch_valid, exp.first_addr, exp.second_addr,
                   exp.needs_second, exp.argb_pixel, exp.coord_error,
                   "\n            got fv=%b a1=%h a2=%h ns=%b argb=%h ce=%b",
                   got.fetch_valid, got.first_addr, got.second_addr,
                   got.needs_second, got.argb_pixel, got.coord_error);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  sfs_pkg::sfs_in_t              in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  sfs_pkg::sfs_out_t             out_data_o;
  logic                          cfg_we_i    = 1'b0;
  logic [sfs_pkg::IDX_BITS-1:0]  cfg_idx_i   = '0;
  logic [sfs_pkg::CFG_BITS-1:0]  cfg_wdata_i = '0;

  scanout_scoreboard sb;
  bit quiet_tail = 1'b0;   // no idling on either side near the end

  scaled_framebuffer_scanout i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop; the slowest legal run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Output side back-pressure: random stall bursts, ready stretches between.
  initial begin
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  // Result monitor. Sampling right at the edge sees pre-edge values, since
  // all drivers here and the DUT flops update in the NBA region.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(out_data_o);
  end

  // ---------------------------------------------------------------------------
  // Driver tasks; all called on a rising edge
  // ---------------------------------------------------------------------------

  // Lower valid and wait for every awaited result to drain out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.predicted_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [sfs_pkg::IDX_BITS-1:0] idx,
                           logic [sfs_pkg::CFG_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Full register setting. Upper data bits are junk so masking is exercised;
  // a stray write to the unused index goes in the middle.
  task automatic apply_setting(logic [sfs_pkg::ADDR_BITS-1:0] origin,
                               logic [sfs_pkg::DIM_BITS-1:0] sw,
                               logic [sfs_pkg::DIM_BITS-1:0] sh,
                               logic [1:0] psc, logic blank,
                               logic [sfs_pkg::DIM_BITS-1:0] ow,
                               logic [sfs_pkg::DIM_BITS-1:0] oh);
    logic [sfs_pkg::CFG_BITS-1:0] junk;
    wait_idle();
    junk = sfs_pkg::CFG_BITS'($urandom);
    write_reg(sfs_pkg::CFG_FRAME_ORIGIN, origin);
    write_reg(sfs_pkg::CFG_SOURCE_WIDTH, {junk[sfs_pkg::CFG_BITS-1:sfs_pkg::DIM_BITS], sw});
    write_reg(sfs_pkg::CFG_SOURCE_HEIGHT, {junk[sfs_pkg::CFG_BITS-1:sfs_pkg::DIM_BITS], sh});
    write_reg(CFG_NO_REG, sfs_pkg::CFG_BITS'($urandom));
    write_reg(sfs_pkg::CFG_PIXEL_SIZE_CODE, {junk[sfs_pkg::CFG_BITS-1:2], psc});
    write_reg(sfs_pkg::CFG_BLANK_ENABLE, {junk[sfs_pkg::CFG_BITS-1:1], blank});
    write_reg(sfs_pkg::CFG_OUTPUT_WIDTH, {junk[sfs_pkg::CFG_BITS-1:sfs_pkg::DIM_BITS], ow});
    write_reg(sfs_pkg::CFG_OUTPUT_HEIGHT, {junk[sfs_pkg::CFG_BITS-1:sfs_pkg::DIM_BITS], oh});
    cfg_we_i <= 1'b0;
  endtask

  // One input transfer, optionally after an idle burst.
  task automatic send_item(sfs_pkg::sfs_in_t item);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(item);
  endtask

  // Unused fields carry random bits so every input bit toggles.
  task automatic locate(logic [sfs_pkg::DIM_BITS-1:0] x, logic [sfs_pkg::DIM_BITS-1:0] y);
    sfs_pkg::sfs_in_t item;
    item.req_type   = REQ_LOCATE;
    item.out_x      = x;
    item.out_y      = y;
    item.pixel_bits = $urandom;
    send_item(item);
  endtask

  task automatic decode(logic [31:0] bits);
    sfs_pkg::sfs_in_t item;
    item.req_type   = REQ_DECODE;
    item.out_x      = sfs_pkg::DIM_BITS'($urandom);
    item.out_y      = sfs_pkg::DIM_BITS'($urandom);
    item.pixel_bits = bits;
    send_item(item);
  endtask

  // Dimension biased toward zero, one and full scale.
  function automatic logic [sfs_pkg::DIM_BITS-1:0] pick_dim(bit allow_zero);
    unique case ($urandom_range(0, 11))
      0:       return allow_zero ? '0 : sfs_pkg::DIM_BITS'(1);
      1:       return '1;
      2:       return sfs_pkg::DIM_BITS'(1);
      3, 4, 5: return sfs_pkg::DIM_BITS'($urandom_range(1, 64));
      default: return sfs_pkg::DIM_BITS'($urandom_range(1, 4095));
    endcase
  endfunction

  function automatic logic [sfs_pkg::ADDR_BITS-1:0] pick_origin();
    unique case ($urandom_range(0, 7))
      0:       return '0;
      1, 2:    return '1 - sfs_pkg::ADDR_BITS'($urandom_range(0, 4096));  // near the wrap
      default: return sfs_pkg::ADDR_BITS'($urandom);
    endcase
  endfunction

  // Mostly in-range coordinates with edge hits; some full-range noise.
  function automatic logic [sfs_pkg::DIM_BITS-1:0] pick_coord(
      logic [sfs_pkg::DIM_BITS-1:0] lim);
    if (lim == '0 || $urandom_range(0, 7) == 0)
      return sfs_pkg::DIM_BITS'($urandom);
    unique case ($urandom_range(0, 9))
      0:       return '0;
      1:       return lim - 1'b1;
      2:       return lim;
      default: return sfs_pkg::DIM_BITS'($urandom_range(0, lim - 1));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sfs_pkg::sfs_in_t item;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: blanked, so everything comes back opaque black
    locate(0, 0);
    locate(320, 0);
    decode(32'h1234_5678);

    // two-byte pixels, 2x upscale
    apply_setting(23'h00_1000, 320, 240, PSC_RGBA5551, 1'b0, 640, 480);
    locate(0, 0);
    locate(639, 479);
    locate(640, 0);
    locate(0, 480);
    locate('1, '1);
    decode(32'hFFFF_FFFF);
    decode(32'h0000_F83F);
    decode(32'hFFFF_07C0);
    decode(32'h0000_0000);

    // four-byte pixels, max sizes, origin at the top so the sum wraps
    apply_setting('1 - 23'd1, '1, '1, sfs_pkg::PSC_RGBA8888, 1'b0, '1, '1);
    locate(4094, 4094);
    locate(1, 0);
    locate(0, 0);
    decode(32'hFF00_FF00);
    decode(32'h00FF_FF01);

    // zero source width forces blanking
    apply_setting(23'h12_3456, 0, 100, sfs_pkg::PSC_RGBA8888, 1'b0, 200, 200);
    locate(10, 10);
    decode(32'hDEAD_BEEF);

    // zero output size: every coordinate is out of range
    apply_setting(23'h00_0100, 64, 64, PSC_RGBA5551, 1'b0, 0, 0);
    locate(0, 0);
    decode(32'hA5A5_A5A5);

    // blank enable with otherwise valid settings
    apply_setting(23'h40_0000, 100, 100, PSC_RGBA5551, 1'b1, 100, 100);
    locate(50, 50);
    locate(100, 5);
    decode(32'h5A5A_5A5A);

    // random phases
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      apply_setting(pick_origin(), pick_dim(1'b1), pick_dim(1'b1),
                    2'($urandom_range(0, 3)), ($urandom_range(0, 4) == 0),
                    pick_dim(1'b1), pick_dim(1'b1));
      if (p == RAND_PHASES - 1)
        quiet_tail = 1'b1;
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        item.req_type   = 1'($urandom_range(0, 1));
        item.out_x      = pick_coord(sb.out_w);
        item.out_y      = pick_coord(sb.out_h);
        item.pixel_bits = $urandom;
        send_item(item);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.predicted_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
